[hdl/cics_pkg.sv]
// Shared types and constants for the custom ISA core step unit.
// No dependencies; every other file in hdl/ refers to it by scoped names.

package cics_pkg;

   localparam int XLEN         = 32;
   localparam int PC_W         = 18;
   localparam int PLEN_W       = 19;
   localparam int FLD_W        = 5;
   localparam int IMM_W        = 16;
   localparam int LD_ADDR_W    = 16;
   localparam int CSR_AW       = 3;
   localparam int CSR_DW       = 32;
   localparam int CSR_IDX_W    = CSR_AW - 2;

   localparam int MEM_WORDS_DEF = 65536;
   localparam int NUM_REGS_DEF  = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_IDX_PROG_LEN = '0;

   typedef enum logic [1:0] {
      KIND_LOAD    = 2'd0,
      KIND_STEP    = 2'd1,
      KIND_READ    = 2'd2,
      KIND_RESTART = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_END     = 2'd1,
      STAT_ILLEGAL = 2'd2,
      STAT_HALTED  = 2'd3
   } status_type;

   typedef enum logic [FLD_W-1:0] {
      OP_SLT  = 5'd0,
      OP_ADD  = 5'd1,
      OP_MUL  = 5'd2,
      OP_SUB  = 5'd3,
      OP_AND  = 5'd4,
      OP_OR   = 5'd5,
      OP_XOR  = 5'd6,
      OP_ADDI = 5'd7,
      OP_SUBI = 5'd8,
      OP_SD   = 5'd9,
      OP_LD   = 5'd10,
      OP_JAL  = 5'd11,
      OP_BEQ  = 5'd12,
      OP_BNE  = 5'd13,
      OP_SLLI = 5'd14,
      OP_SRLI = 5'd15
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DECODE,
      ST_EXEC,
      ST_LOAD
   } state_type;

endpackage

[hdl/cics_if.sv]
// Valid/ready channel interfaces for the request and response sides.
// Depends on cics_pkg for field widths.

interface cics_req_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         kind;
   logic [cics_pkg::LD_ADDR_W-1:0]     address;
   logic signed [cics_pkg::XLEN-1:0]   data;
   logic [cics_pkg::FLD_W-1:0]         reg_index;

   modport source (output valid, kind, address, data, reg_index, input ready);
   modport sink   (input valid, kind, address, data, reg_index, output ready);
endinterface

interface cics_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [cics_pkg::PC_W-1:0]          pc_now;
   logic [1:0]                         status;
   logic signed [cics_pkg::XLEN-1:0]   read_value;

   modport source (output valid, pc_now, status, read_value, input ready);
   modport sink   (input valid, pc_now, status, read_value, output ready);
endinterface

[hdl/custom_isa_core_step_unit.sv]
// Request transfer to response valid: a load, restart or skipped step answers from idle;
// a register read passes the read state, a step decode and execute, an LD step also load.
// Throughput: one load or restart per cycle while the response is not stalled; a read or
// step ends before the next item starts, set by the single-port memory and register file read.
// A one-entry request buffer takes the next transfer while an item executes.
// Synchronous active-high reset clears pc, halt, program length, handshakes and the register
// file valid bits (registers read as zero); word memory contents stay undefined until written.

module custom_isa_core_step_unit #(
   parameter int MEM_WORDS = cics_pkg::MEM_WORDS_DEF,   // power of two
   parameter int NUM_REGS  = cics_pkg::NUM_REGS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   cics_req_if.sink                         req,
   cics_rsp_if.source                       rsp,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [cics_pkg::CSR_AW-1:0]      csr_paddr,
   input  logic [cics_pkg::CSR_DW-1:0]      csr_pwdata,
   output logic [cics_pkg::CSR_DW-1:0]      csr_prdata,
   output logic                             csr_pready
);

   localparam int MA_W = $clog2(MEM_WORDS);
   localparam int RA_W = $clog2(NUM_REGS);
   localparam int XL   = cics_pkg::XLEN;
   localparam int PW   = cics_pkg::PC_W;

   // request buffer
   logic                            buf_valid_ff, buf_valid_in;
   cics_pkg::kind_type              buf_kind_ff;
   logic [cics_pkg::LD_ADDR_W-1:0]  buf_addr_ff;
   logic [XL-1:0]                   buf_data_ff;
   logic [cics_pkg::FLD_W-1:0]      buf_ridx_ff;
   logic                            req_xfer;
   logic                            take;

   // architectural and control state
   cics_pkg::state_type             state_ff, state_in;
   logic [PW-1:0]                   pc_ff, pc_in;
   logic                            halted_ff, halted_in;
   logic [cics_pkg::PLEN_W-1:0]     plen_ff, plen_in;
   logic [XL-1:0]                   ir_ff, ir_in;
   logic [NUM_REGS-1:0]             rf_vld_ff, rf_vld_in;

   // response register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]                   rsp_pc_ff;
   cics_pkg::status_type            rsp_status_ff;
   logic [XL-1:0]                   rsp_value_ff;
   logic                            out_free;
   logic                            emit;
   cics_pkg::status_type            res_status;
   logic [XL-1:0]                   res_value;

   // word memory
   logic [XL-1:0]                   mem_array [MEM_WORDS];
   logic [XL-1:0]                   mem_rdata_ff;
   logic                            mem_we, mem_re;
   logic [MA_W-1:0]                 mem_addr;
   logic [XL-1:0]                   mem_wdata;

   // register file
   logic [XL-1:0]                   rf_array [NUM_REGS];
   logic [XL-1:0]                   rf_rd0_ff, rf_rd1_ff;
   logic                            rf_v0_ff, rf_v1_ff;
   logic                            rf_we, rf_re;
   logic [RA_W-1:0]                 rf_waddr, rf_ra0, rf_ra1;
   logic [XL-1:0]                   rf_wdata;

   // decode / execute
   cics_pkg::opcode_type            op;
   logic [cics_pkg::FLD_W-1:0]      fa, fb, fc;
   logic [cics_pkg::IMM_W-1:0]      imm;
   cics_pkg::opcode_type            fetch_op;
   logic [XL-1:0]                   opb, opy;
   logic [XL-1:0]                   imm_ext;
   logic [XL-1:0]                   daddr;
   logic [XL-1:0]                   prod;
   logic [PW-1:0]                   pc_plus4;
   logic [XL-1:0]                   pc_link;
   logic [XL-1:0]                   jal_base;
   logic [XL-1:0]                   jal_sum;
   logic [XL-1:0]                   fetch_idx;
   logic [XL-1:0]                   load_idx;
   logic                            csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite &
                       (csr_paddr[cics_pkg::CSR_AW-1:2] == cics_pkg::CSR_IDX_PROG_LEN);
   assign plen_in    = csr_wr ? csr_pwdata[cics_pkg::PLEN_W-1:0] : plen_ff;
   assign csr_prdata = (csr_paddr[cics_pkg::CSR_AW-1:2] == cics_pkg::CSR_IDX_PROG_LEN) ?
                       {{(cics_pkg::CSR_DW-cics_pkg::PLEN_W){1'b0}}, plen_ff} : '0;

   assign req.ready   = ~buf_valid_ff | take;
   assign req_xfer    = req.valid & req.ready;
   assign buf_valid_in = req_xfer ? 1'b1 : (take ? 1'b0 : buf_valid_ff);

   assign out_free     = ~rsp_valid_ff | rsp.ready;
   assign rsp_valid_in = emit ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.pc_now     = rsp_pc_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.read_value = rsp_value_ff;

   // instruction fields
   assign op       = cics_pkg::opcode_type'(ir_ff[4:0]);
   assign fa       = ir_ff[9:5];
   assign fb       = ir_ff[14:10];
   assign fc       = ir_ff[19:15];
   assign imm      = ir_ff[30:15];
   assign fetch_op = cics_pkg::opcode_type'(mem_rdata_ff[4:0]);

   // operands: an entry never written since reset reads as zero
   assign opb      = rf_v0_ff ? rf_rd0_ff : '0;
   assign opy      = rf_v1_ff ? rf_rd1_ff : '0;
   assign imm_ext  = {{(XL-cics_pkg::IMM_W){1'b0}}, imm};
   assign daddr    = opb + imm_ext;
   assign prod     = opb * opy;
   assign pc_plus4 = pc_ff + PW'(4);
   // link value is pc + 4 at full register width, not wrapped to the pc width
   assign pc_link  = {{(XL-PW){1'b0}}, pc_ff} + XL'(4);
   // JAL writes the link before r[b] is read, so a == b sees the link value
   assign jal_base = (fa == fb) ? pc_link : opb;
   assign jal_sum  = jal_base + {{(XL-cics_pkg::IMM_W+2){1'b0}}, imm[cics_pkg::IMM_W-1:2]};
   assign fetch_idx = {{(XL-PW+2){1'b0}}, pc_ff[PW-1:2]};
   assign load_idx  = {{(XL-cics_pkg::LD_ADDR_W){1'b0}}, buf_addr_ff};

   assign rf_vld_in = rf_we ? (rf_vld_ff | (NUM_REGS'(1) << rf_waddr)) : rf_vld_ff;

   // output / control decode
   always_comb begin
      take       = 1'b0;
      emit       = 1'b0;
      res_status = cics_pkg::STAT_OK;
      res_value  = '0;
      pc_in      = pc_ff;
      halted_in  = halted_ff;
      ir_in      = ir_ff;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_addr   = fetch_idx[MA_W-1:0];
      mem_wdata  = opy;
      rf_we      = 1'b0;
      rf_re      = 1'b0;
      rf_waddr   = RA_W'(fa);
      rf_wdata   = '0;
      rf_ra0     = RA_W'(buf_ridx_ff);
      rf_ra1     = RA_W'(buf_ridx_ff);
      unique case (state_ff)
         cics_pkg::ST_IDLE: begin
            if (buf_valid_ff) begin
               unique case (buf_kind_ff)
                  cics_pkg::KIND_LOAD: begin
                     if (out_free) begin
                        mem_we    = 1'b1;
                        mem_addr  = load_idx[MA_W-1:0];
                        mem_wdata = buf_data_ff;
                        emit      = 1'b1;
                        take      = 1'b1;
                     end
                  end
                  cics_pkg::KIND_RESTART: begin
                     if (out_free) begin
                        pc_in     = '0;
                        halted_in = 1'b0;
                        emit      = 1'b1;
                        take      = 1'b1;
                     end
                  end
                  cics_pkg::KIND_READ: begin
                     rf_re = 1'b1;
                     take  = 1'b1;
                  end
                  cics_pkg::KIND_STEP: begin
                     if (halted_ff) begin
                        if (out_free) begin
                           res_status = cics_pkg::STAT_HALTED;
                           emit       = 1'b1;
                           take       = 1'b1;
                        end
                     end else if ({1'b0, pc_ff} >= plen_ff) begin
                        if (out_free) begin
                           halted_in  = 1'b1;
                           res_status = cics_pkg::STAT_END;
                           emit       = 1'b1;
                           take       = 1'b1;
                        end
                     end else begin
                        mem_re = 1'b1;
                        take   = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         cics_pkg::ST_READ: begin
            if (out_free) begin
               res_value = opb;
               emit      = 1'b1;
            end
         end
         cics_pkg::ST_DECODE: begin
            ir_in  = mem_rdata_ff;
            rf_re  = 1'b1;
            rf_ra0 = RA_W'(mem_rdata_ff[14:10]);
            // stores and branches need r[a] on the second port instead of r[c]
            if (fetch_op == cics_pkg::OP_SD || fetch_op == cics_pkg::OP_BEQ ||
                fetch_op == cics_pkg::OP_BNE) begin
               rf_ra1 = RA_W'(mem_rdata_ff[9:5]);
            end else begin
               rf_ra1 = RA_W'(mem_rdata_ff[19:15]);
            end
         end
         cics_pkg::ST_EXEC: begin
            if (out_free) begin
               emit  = 1'b1;
               pc_in = pc_plus4;
               rf_we = 1'b1;
               unique case (op)
                  cics_pkg::OP_SLT:  rf_wdata = {{(XL-1){1'b0}}, $signed(opb) < $signed(opy)};
                  cics_pkg::OP_ADD:  rf_wdata = opb + opy;
                  cics_pkg::OP_MUL:  rf_wdata = prod;
                  cics_pkg::OP_SUB:  rf_wdata = opb - opy;
                  cics_pkg::OP_AND:  rf_wdata = opb & opy;
                  cics_pkg::OP_OR:   rf_wdata = opb | opy;
                  cics_pkg::OP_XOR:  rf_wdata = opb ^ opy;
                  cics_pkg::OP_ADDI: rf_wdata = opb + imm_ext;
                  cics_pkg::OP_SUBI: rf_wdata = opb - imm_ext;
                  cics_pkg::OP_SD: begin
                     rf_we    = 1'b0;
                     mem_we   = 1'b1;
                     mem_addr = daddr[MA_W-1:0];
                  end
                  cics_pkg::OP_LD: begin
                     // finish in the load state once the data word is back
                     rf_we    = 1'b0;
                     emit     = 1'b0;
                     pc_in    = pc_ff;
                     mem_re   = 1'b1;
                     mem_addr = daddr[MA_W-1:0];
                  end
                  cics_pkg::OP_JAL: begin
                     rf_wdata = pc_link;
                     pc_in    = {jal_sum[PW-3:0], 2'b00};
                  end
                  cics_pkg::OP_BEQ: begin
                     rf_we = 1'b0;
                     if (opb == opy) pc_in = {{(PW-cics_pkg::IMM_W){1'b0}}, imm};
                  end
                  cics_pkg::OP_BNE: begin
                     rf_we = 1'b0;
                     if (opb != opy) pc_in = {{(PW-cics_pkg::IMM_W){1'b0}}, imm};
                  end
                  cics_pkg::OP_SLLI: rf_wdata = opb << fc;
                  cics_pkg::OP_SRLI: rf_wdata = opb >> fc;
                  default: begin
                     // opcodes with the top bit set halt in place
                     rf_we      = 1'b0;
                     pc_in      = pc_ff;
                     halted_in  = 1'b1;
                     res_status = cics_pkg::STAT_ILLEGAL;
                  end
               endcase
            end
         end
         cics_pkg::ST_LOAD: begin
            if (out_free) begin
               rf_we    = 1'b1;
               rf_wdata = mem_rdata_ff;
               pc_in    = pc_plus4;
               emit     = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cics_pkg::ST_IDLE: begin
            if (mem_re)     state_in = cics_pkg::ST_DECODE;
            else if (rf_re) state_in = cics_pkg::ST_READ;
         end
         cics_pkg::ST_READ:   if (emit) state_in = cics_pkg::ST_IDLE;
         cics_pkg::ST_DECODE: state_in = cics_pkg::ST_EXEC;
         cics_pkg::ST_EXEC: begin
            if (mem_re)    state_in = cics_pkg::ST_LOAD;
            else if (emit) state_in = cics_pkg::ST_IDLE;
         end
         cics_pkg::ST_LOAD:   if (emit) state_in = cics_pkg::ST_IDLE;
         default:             state_in = cics_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cics_pkg::ST_IDLE;
         buf_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= '0;
         halted_ff    <= 1'b0;
         plen_ff      <= '0;
         rf_vld_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         buf_valid_ff <= buf_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pc_ff        <= pc_in;
         halted_ff    <= halted_in;
         plen_ff      <= plen_in;
         rf_vld_ff    <= rf_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      ir_ff <= ir_in;
      if (req_xfer) begin
         buf_kind_ff <= cics_pkg::kind_type'(req.kind);
         buf_addr_ff <= req.address;
         buf_data_ff <= req.data;
         buf_ridx_ff <= req.reg_index;
      end
      if (emit) begin
         rsp_pc_ff     <= pc_in;
         rsp_status_ff <= res_status;
         rsp_value_ff  <= res_value;
      end
   end

   // word memory: one port, read data held until the next read
   always_ff @(posedge clock) begin
      if (mem_we) mem_array[mem_addr] <= mem_wdata;
      if (mem_re) mem_rdata_ff <= mem_array[mem_addr];
   end

   // register file: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (rf_we) rf_array[rf_waddr] <= rf_wdata;
      if (rf_re) begin
         rf_rd0_ff <= rf_array[rf_ra0];
         rf_rd1_ff <= rf_array[rf_ra1];
         rf_v0_ff  <= rf_vld_ff[rf_ra0];
         rf_v1_ff  <= rf_vld_ff[rf_ra1];
      end
   end

endmodule

[hdl/cics_checker.sv]
// Port-level checks for custom_isa_core_step_unit, attached by bind.
// Depends on cics_pkg for the status codes.

module cics_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [cics_pkg::PC_W-1:0]        rsp_pc_now,
   input logic [1:0]                       rsp_status,
   input logic [cics_pkg::XLEN-1:0]        rsp_read_value
);

   // response held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_pc_now) && $stable(rsp_status) &&
                                  $stable(rsp_read_value))
      else $error("response payload changed while stalled");

   // nothing is presented right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // only read transfers carry a value: a non-ok response must show a zero read value
   a_status_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != cics_pkg::STAT_OK) |-> rsp_read_value == '0)
      else $error("nonzero read value on a step response");

endmodule

bind custom_isa_core_step_unit cics_checker u_cics_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_pc_now     (rsp.pc_now),
   .rsp_status     (rsp.status),
   .rsp_read_value (rsp.read_value)
);
